// ===== rtl/character_ngram_generator_assert.svh =====
// assertion macros for the character n-gram generator
`ifndef CHARACTER_NGRAM_GENERATOR_ASSERT_SVH
`define CHARACTER_NGRAM_GENERATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CNG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cng assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define CNG_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cng assertion failed: next-cycle implication");

`endif

// ===== rtl/cng_pkg.sv =====
// shared types and constants of the character n-gram generator
`default_nettype none

package cng_pkg;

  localparam int WINDOW_SIZE_DEF = 4;

  localparam int CHAR_W      = 21;
  localparam int LEN_W       = 3;
  localparam int IDX_W       = 2;
  localparam int CNT_W       = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [LEN_W-1:0] GRAM_LO_RST   = 3'd1;
  localparam logic [LEN_W-1:0] GRAM_HI_RST   = 3'd2;
  localparam logic             LEAD_ONLY_RST = 1'b0;

  typedef enum logic [1:0] {
    REG_GRAM_LO,
    REG_GRAM_HI,
    REG_LEAD_ONLY
  } cng_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_EMIT
  } cng_state_t;

  typedef struct packed {
    logic [LEN_W-1:0] gram_lo;
    logic [LEN_W-1:0] gram_hi;
    logic             lead_only;
  } cng_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/character_ngram_generator.sv =====
// an item is accepted in ST_IDLE and planned in ST_FIRST; ST_EMIT then gives one gram
// character per cycle while unstalled; a new item is taken only back in ST_IDLE
// results leave through an output register, so downstream stalls pause the walk
// reset (synchronous, active low): window cleared, shortest gram 1, longest gram 2,
// lead-only mode off, output empty
`default_nettype none

module character_ngram_generator import cng_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [20:0] code_point, rest zero
  input  logic                   in_tuser,   // [0] is_token
  input  logic                   in_tlast,   // end_of_text
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [20:0] gram_char, [23:21] gram_length,
                                             // [25:24] char_index, rest zero
  output logic                   out_tuser,  // [0] gram_done
  output logic                   out_tlast,  // item_done
  // configuration
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int               SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam logic [CNT_W-1:0] WIN    = CNT_W'(WINDOW_SIZE);
  localparam int               PAD_W  = OUT_TDATA_W - CHAR_W - LEN_W - IDX_W;

  // configuration registers
  cng_cfg_t cfg_r;
  cng_reg_t cfg_sel;
  logic     cfg_wr;

  // window state
  logic [CHAR_W-1:0]      win_char_r   [WINDOW_SIZE];
  logic [CHAR_W-1:0]      win_char_nxt [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] win_tok_r, win_tok_nxt;
  logic [WINDOW_SIZE-1:0] brk_r, brk_nxt;
  logic [CNT_W-1:0]       seen_r, seen_nxt;
  logic                   eot_r, eot_nxt;

  // sequencer
  cng_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] s_r, s_nxt;
  logic [LEN_W-1:0]  g_r, g_nxt;
  logic [LEN_W-1:0]  k_r, k_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic              out_gdone_r, out_gdone_nxt;
  logic              out_last_r, out_last_nxt;

  // plan
  logic [LEN_W-1:0]                  mn;
  logic [WINDOW_SIZE-1:0]            emit_mask;
  logic [WINDOW_SIZE-1:0][LEN_W-1:0] top_len;

  logic              in_acc;
  logic              adv;
  logic [SLOT_W-1:0] first_s;
  logic [SLOT_W-1:0] next_s;
  logic              next_found;
  logic [LEN_W-1:0]  cur_top;
  logic              gram_end;
  logic              item_end;
  logic              finish;
  logic [CNT_W-1:0]  slot_sum;
  logic [SLOT_W-1:0] rd_slot;
  logic              nbrk;

  // ---------------------------------------------------------------- config

  assign cfg_pready = 1'b1;
  assign cfg_sel    = cng_reg_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gram_lo   <= GRAM_LO_RST;
      cfg_r.gram_hi   <= GRAM_HI_RST;
      cfg_r.lead_only <= LEAD_ONLY_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_GRAM_LO:   cfg_r.gram_lo   <= cfg_pwdata[LEN_W-1:0];
        REG_GRAM_HI:   cfg_r.gram_hi   <= cfg_pwdata[LEN_W-1:0];
        REG_LEAD_ONLY: cfg_r.lead_only <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_GRAM_LO:   cfg_prdata = CFG_DATA_W'(cfg_r.gram_lo);
      REG_GRAM_HI:   cfg_prdata = CFG_DATA_W'(cfg_r.gram_hi);
      REG_LEAD_ONLY: cfg_prdata = CFG_DATA_W'(cfg_r.lead_only);
      default:       cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- plan

  cng_plan #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_plan (
    .cfg       (cfg_r),
    .win_tok   (win_tok_r),
    .brk       (brk_r),
    .seen      (seen_r),
    .eot       (eot_r),
    .mn        (mn),
    .emit_mask (emit_mask),
    .top_len   (top_len)
  );

  // ---------------------------------------------------------------- walk control

  assign in_acc = in_tvalid && in_tready;
  assign adv    = !out_valid_r || out_tready;
  assign nbrk   = (seen_r == '0) || !win_tok_r[WINDOW_SIZE-1];

  always_comb begin
    first_s    = '0;
    next_s     = '0;
    next_found = 1'b0;
    // downward scan leaves the lowest match
    for (int i = WINDOW_SIZE - 1; i >= 0; i--) begin
      if (emit_mask[i]) begin
        first_s = SLOT_W'(i);
      end
      if (emit_mask[i] && (i > int'(s_r))) begin
        next_s     = SLOT_W'(i);
        next_found = 1'b1;
      end
    end
  end

  assign cur_top  = top_len[s_r];
  assign gram_end = (k_r == (g_r - LEN_W'(1)));
  assign item_end = gram_end && (g_r == cur_top) && !next_found;
  assign finish   = ((state_r == ST_FIRST) && (emit_mask == '0))
                 || ((state_r == ST_EMIT) && adv && item_end);
  assign slot_sum = CNT_W'(s_r) + k_r;
  assign rd_slot  = slot_sum[SLOT_W-1:0];

  // next state
  always_comb begin
    case (state_r)
      ST_IDLE:  state_nxt = in_acc ? ST_FIRST : ST_IDLE;
      ST_FIRST: state_nxt = (emit_mask != '0) ? ST_EMIT : ST_IDLE;
      ST_EMIT:  state_nxt = (adv && item_end) ? ST_IDLE : ST_EMIT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    in_tready = (state_r == ST_IDLE);

    win_char_nxt = win_char_r;
    win_tok_nxt  = win_tok_r;
    brk_nxt      = brk_r;
    seen_nxt     = seen_r;
    eot_nxt      = eot_r;
    s_nxt        = s_r;
    g_nxt        = g_r;
    k_nxt        = k_r;

    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_len_nxt   = out_len_r;
    out_idx_nxt   = out_idx_r;
    out_gdone_nxt = out_gdone_r;
    out_last_nxt  = out_last_r;

    if (in_acc) begin
      for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
        win_char_nxt[i] = win_char_r[i+1];
        win_tok_nxt[i]  = win_tok_r[i+1];
        brk_nxt[i]      = brk_r[i+1];
      end
      win_char_nxt[WINDOW_SIZE-1] = in_tdata[CHAR_W-1:0];
      win_tok_nxt[WINDOW_SIZE-1]  = in_tuser;
      brk_nxt[WINDOW_SIZE-1]      = nbrk;
      seen_nxt = (seen_r < WIN) ? (seen_r + CNT_W'(1)) : seen_r;
      eot_nxt  = in_tlast;
    end

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (state_r == ST_FIRST) begin
      s_nxt = first_s;
      g_nxt = mn;
      k_nxt = '0;
    end

    if ((state_r == ST_EMIT) && adv) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = win_char_r[rd_slot];
      out_len_nxt   = g_r;
      out_idx_nxt   = k_r[IDX_W-1:0];
      out_gdone_nxt = gram_end;
      out_last_nxt  = item_end;
      if (!gram_end) begin
        k_nxt = k_r + LEN_W'(1);
      end else if (g_r != cur_top) begin
        g_nxt = g_r + LEN_W'(1);
        k_nxt = '0;
      end else begin
        s_nxt = next_s;
        g_nxt = mn;
        k_nxt = '0;
      end
    end

    // end of text empties the window once the item is finished
    if (finish && eot_r) begin
      win_tok_nxt = '0;
      brk_nxt     = '1;
      seen_nxt    = '0;
      eot_nxt     = 1'b0;
    end
  end

  // ---------------------------------------------------------------- registers

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_tok_r   <= '0;
      brk_r       <= '1;
      seen_r      <= '0;
      eot_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_tok_r   <= win_tok_nxt;
      brk_r       <= brk_nxt;
      seen_r      <= seen_nxt;
      eot_r       <= eot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_char_r  <= win_char_nxt;
    s_r         <= s_nxt;
    g_r         <= g_nxt;
    k_r         <= k_nxt;
    out_char_r  <= out_char_nxt;
    out_len_r   <= out_len_nxt;
    out_idx_r   <= out_idx_nxt;
    out_gdone_r <= out_gdone_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_idx_r, out_len_r, out_char_r};
  assign out_tuser  = out_gdone_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------- assertions

`include "character_ngram_generator_assert.svh"

  `CNG_ASSERT_IMP(a_char_in_gram, state_r == ST_EMIT, k_r < g_r)
  `CNG_ASSERT_IMP(a_start_planned, state_r == ST_EMIT, emit_mask[s_r])
  `CNG_ASSERT_IMP(a_last_ends_gram, out_tvalid && out_tlast, out_tuser)
  `CNG_ASSERT_NEXT(a_last_loaded, (state_r == ST_EMIT) && adv && item_end, out_tvalid && out_tlast)

endmodule

`default_nettype wire

// ===== rtl/cng_plan.sv =====
// per-start planning: which window starts emit and their longest clean gram
`default_nettype none

module cng_plan import cng_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  cng_cfg_t                              cfg,
  input  logic [WINDOW_SIZE-1:0]                win_tok,
  input  logic [WINDOW_SIZE-1:0]                brk,
  input  logic [CNT_W-1:0]                      seen,
  input  logic                                  eot,
  output logic [LEN_W-1:0]                      mn,
  output logic [WINDOW_SIZE-1:0]                emit_mask,
  output logic [WINDOW_SIZE-1:0][LEN_W-1:0]     top_len
);

  localparam logic [CNT_W-1:0] WIN = CNT_W'(WINDOW_SIZE);

  logic [LEN_W-1:0] mx;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic             has_range;
  logic [CNT_W-1:0] run;
  logic [CNT_W-1:0] avail;
  logic [CNT_W-1:0] top;
  logic [CNT_W-1:0] eff;
  logic [CNT_W-1:0] s_v;
  logic             stop;

  always_comb begin
    mn = (cfg.gram_lo == '0) ? LEN_W'(1) : cfg.gram_lo;
    mx = (cfg.gram_hi > WIN) ? WIN : cfg.gram_hi;

    // starts that become final with this item
    if (!eot) begin
      has_range = (seen >= mx);
      lo        = WIN - mx;
      hi        = WIN - mx;
    end else begin
      has_range = 1'b1;
      lo        = WIN - mx;
      if ((WIN - seen) > lo) begin
        lo = WIN - seen;
      end
      hi        = WIN - CNT_W'(1);
    end

    run   = '0;
    avail = '0;
    top   = '0;
    eff   = '0;
    s_v   = '0;
    stop  = 1'b0;
    for (int s = 0; s < WINDOW_SIZE; s++) begin
      s_v   = CNT_W'(s);
      avail = WIN - s_v;
      top   = (mx < avail) ? mx : avail;
      // length of the token run that begins at this start
      run   = '0;
      stop  = 1'b0;
      for (int j = 0; j < WINDOW_SIZE; j++) begin
        if (j >= s) begin
          if (!stop && win_tok[j]) begin
            run = run + CNT_W'(1);
          end else begin
            stop = 1'b1;
          end
        end
      end
      eff          = (top < run) ? top : run;
      top_len[s]   = eff;
      emit_mask[s] = (mn <= mx) && has_range && (s_v >= lo) && (s_v <= hi)
                     && !(cfg.lead_only && !brk[s]) && (mn <= eff);
    end
  end

endmodule

`default_nettype wire

// ===== dv/character_ngram_generator_tb.sv =====
// self-checking testbench for the character n-gram generator
`timescale 1ns / 1ps

module character_ngram_generator_tb;
  import cng_pkg::*;

  localparam int WIN            = WINDOW_SIZE_DEF;
  localparam int RAND_ITEMS     = 400;
  localparam int N_PHASES       = 8;
  localparam int TAIL_ITEMS     = 40;
  localparam int LONG_HOLD      = 250;
  localparam int HOLD_AT        = 30;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PREDICTED      = -1;
  localparam int N_DIR          = 25;

  // one gram character as it leaves the block
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    logic [IDX_W-1:0]  idx;
    logic              gdone;
    logic              idone;
  } gram_res_t;

  typedef struct packed {
    logic              is_cfg;
    cng_reg_t          reg_sel;
    logic [LEN_W-1:0]  val;
    logic [CHAR_W-1:0] cp;
    logic              tok;
    logic              eot;
    int                n_exp;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [20:0] code_point, rest zero
  logic                   in_tuser = 1'b0; // [0] is_token
  logic                   in_tlast = 1'b0; // end_of_text
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [20:0] gram_char, [23:21] gram_length,
                                           // [25:24] char_index, rest zero
  logic                   out_tuser;       // [0] gram_done
  logic                   out_tlast;       // item_done
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  // predictor state
  logic [CHAR_W-1:0] win_ch [WIN];
  logic              win_tok [WIN];
  logic              win_brk [WIN];
  int                chars_held;
  logic [LEN_W-1:0]  cfg_min = GRAM_LO_RST;
  logic [LEN_W-1:0]  cfg_max = GRAM_HI_RST;
  logic              cfg_edges = LEAD_ONLY_RST;
  gram_res_t         gram_q [$];

  gram_res_t got_res;
  gram_res_t want_res;
  int        n_mismatch = 0;
  int        n_items = 0;
  int        n_results = 0;
  int        n_settings = 0;
  int        send_calm = 0;
  bit        tail_phase = 1'b0;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;

  dir_row_t dir_tab [N_DIR] = '{
    // reset setting: min 1, max 2, all starts
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h00061,  1'b1, 1'b0, 0},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h1FFFFF, 1'b1, 1'b0, 3},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h00000,  1'b0, 1'b0, 1},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h10FFFF, 1'b1, 1'b0, 0},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h55555,  1'b1, 1'b1, 4},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h0AAAAA, 1'b1, 1'b1, 1},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h00078,  1'b0, 1'b1, 0},
    // min above max emits nothing
    '{1'b1, REG_GRAM_LO,   3'd3, 21'h0,      1'b0, 1'b0, 0},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h00062,  1'b1, 1'b0, 0},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h00063,  1'b1, 1'b0, 0},
    // min of zero, max beyond the window, changed mid-text
    '{1'b1, REG_GRAM_LO,   3'd0, 21'h0,      1'b0, 1'b0, 0},
    '{1'b1, REG_GRAM_HI,   3'd7, 21'h0,      1'b0, 1'b0, 0},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h00064,  1'b1, 1'b0, 0},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h00065,  1'b1, 1'b1, 20},
    // max of zero
    '{1'b1, REG_GRAM_HI,   3'd0, 21'h0,      1'b0, 1'b0, 0},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h00066,  1'b1, 1'b1, 0},
    // edges only over two token runs
    '{1'b1, REG_GRAM_HI,   3'd3, 21'h0,      1'b0, 1'b0, 0},
    '{1'b1, REG_GRAM_LO,   3'd2, 21'h0,      1'b0, 1'b0, 0},
    '{1'b1, REG_LEAD_ONLY, 3'd1, 21'h0,      1'b0, 1'b0, 0},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h00061,  1'b1, 1'b0, PREDICTED},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h00062,  1'b1, 1'b0, PREDICTED},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h00020,  1'b0, 1'b0, PREDICTED},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h00063,  1'b1, 1'b0, PREDICTED},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h00064,  1'b1, 1'b0, PREDICTED},
    '{1'b0, REG_GRAM_LO,   3'd0, 21'h00065,  1'b1, 1'b1, PREDICTED}
  };

  character_ngram_generator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void flag_error(string msg);
    if (n_mismatch < 10) $display("mismatch: %s", msg);
    n_mismatch++;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < WIN; i++) begin
      win_ch[i]  = '0;
      win_tok[i] = 1'b0;
      win_brk[i] = 1'b1;
    end
    chars_held = 0;
  endfunction

  // shifts the character in and queues every gram character it releases
  function automatic int predict_grams(logic [CHAR_W-1:0] cp, logic tok, logic eot);
    logic      brk;
    int        mn, mx, lo, hi, top, n;
    bit        clean;
    gram_res_t r;
    brk = (chars_held == 0) || !win_tok[WIN-1];
    for (int i = 0; i < WIN - 1; i++) begin
      win_ch[i]  = win_ch[i+1];
      win_tok[i] = win_tok[i+1];
      win_brk[i] = win_brk[i+1];
    end
    win_ch[WIN-1]  = cp;
    win_tok[WIN-1] = tok;
    win_brk[WIN-1] = brk;
    if (chars_held < WIN) chars_held++;
    mn = (cfg_min == 0) ? 1 : int'(cfg_min);
    mx = (cfg_max > WIN) ? WIN : int'(cfg_max);
    n = 0;
    if (mn <= mx) begin
      lo = 1;
      hi = 0;
      if (!eot) begin
        if (chars_held >= mx) begin
          lo = WIN - mx;
          hi = lo;
        end
      end else begin
        // end of text: flush every start still waiting
        lo = WIN - mx;
        if (WIN - chars_held > lo) lo = WIN - chars_held;
        hi = WIN - 1;
      end
      for (int s = lo; s <= hi; s++) begin
        top = (mx < WIN - s) ? mx : WIN - s;
        if (cfg_edges && !win_brk[s]) continue;
        for (int g = mn; g <= top; g++) begin
          clean = 1'b1;
          for (int k = 0; k < g; k++) if (!win_tok[s+k]) clean = 1'b0;
          if (!clean) break;
          for (int k = 0; k < g; k++) begin
            r.ch    = win_ch[s+k];
            r.len   = LEN_W'(g);
            r.idx   = IDX_W'(k);
            r.gdone = (k == g - 1);
            r.idone = 1'b0;
            gram_q.push_back(r);
            n++;
          end
        end
      end
    end
    if (n > 0) gram_q[gram_q.size()-1].idone = 1'b1;
    if (eot) clear_window();
    return n;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_code_point();
    case ($urandom_range(0, 3))
      0:       return CHAR_W'($urandom);
      1:       return CHAR_W'($urandom_range(0, 21'h10FFFF));
      default: return CHAR_W'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  task automatic send_char(logic [CHAR_W-1:0] cp, logic tok, logic eot, output int n_pred);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(cp);
    in_tuser  <= tok;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
    n_pred = predict_grams(cp, tok, eot);
    n_items++;
    if (!tail_phase && send_calm == 0 && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      send_calm = $urandom_range(0, 1) ? $urandom_range(10, 40) : 0;
    end else if (send_calm > 0) begin
      send_calm--;
    end
  endtask

  // lets the pipeline drain so that a register can change safely
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (gram_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(cng_reg_t r, logic [LEN_W-1:0] val);
    logic [LEN_W-1:0] stored;
    stored = (r == REG_LEAD_ONLY) ? LEN_W'(val[0]) : val;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * int'(r));
    cfg_pwdata  <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (r)
      REG_GRAM_LO:   cfg_min = val;
      REG_GRAM_HI:   cfg_max = val;
      REG_LEAD_ONLY: cfg_edges = val[0];
      default:       ;
    endcase
    n_settings++;
    // read the register back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DATA_W'(stored))
      flag_error($sformatf("register %s read %h, wrote %h", r.name(), cfg_prdata, stored));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off, none in the tail
  initial begin : sink
    int calm;
    calm = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
        hold_done = 1'b1;
      end else if (!tail_phase && calm == 0 && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_tready <= 1'b1;
        calm = $urandom_range(0, 1) ? $urandom_range(20, 60) : 0;
      end else begin
        out_tready <= 1'b1;
        if (calm > 0) calm--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      got_res.ch    = out_tdata[20:0];
      got_res.len   = out_tdata[23:21];
      got_res.idx   = out_tdata[25:24];
      got_res.gdone = out_tuser;
      got_res.idone = out_tlast;
      if (gram_q.size() == 0) begin
        flag_error($sformatf("unexpected result tdata=%h tuser=%b tlast=%b",
                             out_tdata, out_tuser, out_tlast));
      end else begin
        want_res = gram_q.pop_front();
        if (got_res !== want_res || out_tdata[31:26] !== '0)
          flag_error($sformatf(
            "char %h/%h len %0d/%0d idx %0d/%0d gdone %b/%b idone %b/%b pad %h (exp/got)",
            want_res.ch, got_res.ch, want_res.len, got_res.len, want_res.idx, got_res.idx,
            want_res.gdone, got_res.gdone, want_res.idone, got_res.idone,
            out_tdata[31:26]));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int            n_pred, len, kind, phase_sent, rand_sent;
    logic          tok, eot;
    logic [LEN_W-1:0] mn, mx;
    clear_window();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].is_cfg) begin
        wait_idle();
        reg_write(dir_tab[i].reg_sel, dir_tab[i].val);
      end else begin
        send_char(dir_tab[i].cp, dir_tab[i].tok, dir_tab[i].eot, n_pred);
        if (dir_tab[i].n_exp != PREDICTED && n_pred != dir_tab[i].n_exp)
          flag_error($sformatf("row %0d gives %0d gram chars, table lists %0d",
                               i, n_pred, dir_tab[i].n_exp));
      end
    end

    rand_sent = 0;
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin mn = 3'd1; mx = 3'd4; eot = 1'b0; end
        1: begin mn = 3'd4; mx = 3'd4; eot = 1'b1; end
        2: begin mn = 3'd1; mx = 3'd1; eot = 1'b0; end
        3: begin mn = 3'd0; mx = 3'd7; eot = 1'b1; end
        4: begin mn = 3'd2; mx = 3'd3; eot = 1'b0; end
        default: begin
          mn  = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 3));
          mx  = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(2, 4));
          eot = 1'($urandom_range(0, 1));
        end
      endcase
      reg_write(REG_GRAM_LO, mn);
      reg_write(REG_GRAM_HI, mx);
      reg_write(REG_LEAD_ONLY, {2'b00, eot});

      phase_sent = 0;
      while (phase_sent < RAND_ITEMS / N_PHASES) begin
        // mostly texts of token runs; some noise, some cut off without an end mark
        kind = $urandom_range(0, 9);
        len  = $urandom_range(1, 9);
        for (int j = 0; j < len && phase_sent < RAND_ITEMS / N_PHASES; j++) begin
          tok = (kind == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 5) != 0);
          eot = (j == len - 1) && (kind != 1);
          if (rand_sent == HOLD_AT) hold_req = 1'b1;
          if (rand_sent >= RAND_ITEMS - TAIL_ITEMS) tail_phase = 1'b1;
          send_char(pick_code_point(), tok, eot, n_pred);
          phase_sent++;
          rand_sent++;
        end
      end
    end

    wait_idle();
    if (gram_q.size() != 0)
      flag_error($sformatf("%0d gram chars never arrived", gram_q.size()));
    $display("run covered %0d characters over %0d register writes, %0d gram chars checked",
             n_items, n_settings, n_results);
    $display("output held off for %0d cycles once; %0d mismatches", LONG_HOLD, n_mismatch);
    if (n_mismatch == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
